// File: sv/sle_pkg.sv
package sle_pkg;

  localparam int DEFAULT_CAPACITY = 16;
  localparam int KIND_W  = 3;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 8;
  localparam int COUNT_W = 5;

  typedef enum logic [KIND_W-1:0] {
    K_INSERT = 3'd0,
    K_RMIN   = 3'd1,
    K_RMAX   = 3'd2,
    K_READ   = 3'd3,
    K_CLEAR  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // read address source
  typedef enum logic [2:0] {
    RA_ZERO,
    RA_TOP,
    RA_POS,
    RA_DN,
    RA_UP
  } rd_sel_t;

  // write address / data source
  typedef enum logic [2:0] {
    WR_NONE,
    WR_UP_RDATA,
    WR_UP_VAL,
    WR_ZERO_VAL,
    WR_DN_RDATA
  } wr_sel_t;

  typedef enum logic [1:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_TOP,
    IDX_STEP
  } idx_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_CLR
  } cnt_op_t;

  typedef struct packed {
    logic    latch_op;
    logic    rd_en;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    idx_op_t idx_op;
    logic    idx_down;
    cnt_op_t cnt_op;
    logic    set_status;
    status_t status;
    logic    capture;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              empty;
    logic              full;
    logic              pos_bad;
    logic              idx_zero;
    logic              idx_last;
    logic              greater;
  } dp_stat_t;

endpackage

// File: sv/sle_req_if.sv
interface sle_req_if;
  import sle_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [KIND_W-1:0]          kind;
  logic signed [VALUE_W-1:0]  value;
  logic [POS_W-1:0]           position;

  modport source (output valid, output kind, output value, output position, input ready);
  modport sink (input valid, input kind, input value, input position, output ready);
endinterface

// File: sv/sle_rsp_if.sv
interface sle_rsp_if;
  import sle_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  result_value;
  logic [1:0]                 status;
  logic [COUNT_W-1:0]         count;

  modport source (output valid, output result_value, output status, output count, input ready);
  modport sink (input valid, input result_value, input status, input count, output ready);
endinterface

// File: sv/sle_dp.sv
module sle_dp #(
  parameter int CAPACITY = sle_pkg::DEFAULT_CAPACITY
) (
  input  logic                               clk,
  input  logic                               rst,
  input  sle_pkg::dp_cmd_t                   cmd,
  output sle_pkg::dp_stat_t                  stat,
  input  logic [sle_pkg::KIND_W-1:0]         in_kind,
  input  logic signed [sle_pkg::VALUE_W-1:0] in_value,
  input  logic [sle_pkg::POS_W-1:0]          in_position,
  output logic signed [sle_pkg::VALUE_W-1:0] out_value,
  output logic [1:0]                         out_status,
  output logic [sle_pkg::COUNT_W-1:0]        out_count
);
  import sle_pkg::*;

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  logic signed [VALUE_W-1:0] mem [CAPACITY];
  logic signed [VALUE_W-1:0] rdata;

  logic [KIND_W-1:0]         op_kind;
  logic signed [VALUE_W-1:0] op_value;
  logic [POS_W-1:0]          op_pos;

  logic [CW-1:0]             fill;
  logic [CW-1:0]             fill_m1;
  logic [AW-1:0]             idx;
  logic [AW-1:0]             idx_dn;
  logic [AW-1:0]             idx_up;
  logic [AW-1:0]             top;

  logic signed [VALUE_W-1:0] res_value;
  status_t                   res_status;

  logic [AW-1:0]             raddr;
  logic [AW-1:0]             waddr;
  logic signed [VALUE_W-1:0] wdata;

  assign fill_m1 = fill - CW'(1);
  assign top     = fill_m1[AW-1:0];
  assign idx_dn  = idx - AW'(1);
  assign idx_up  = idx + AW'(1);

  assign stat.kind     = op_kind;
  assign stat.empty    = (fill == '0);
  assign stat.full     = (fill == CW'(CAPACITY));
  assign stat.pos_bad  = (CMPW'(op_pos) >= CMPW'(fill));
  assign stat.idx_zero = (idx == '0);
  assign stat.idx_last = (CW'(idx) == fill_m1);
  assign stat.greater  = (rdata > op_value);

  always_comb begin
    unique case (cmd.rd_sel)
      RA_ZERO: raddr = '0;
      RA_TOP:  raddr = top;
      RA_POS:  raddr = op_pos[AW-1:0];
      RA_DN:   raddr = idx_dn;
      RA_UP:   raddr = idx_up;
      default: raddr = '0;
    endcase
  end

  always_comb begin
    unique case (cmd.wr_sel)
      WR_UP_RDATA: begin
        waddr = idx_up;
        wdata = rdata;
      end
      WR_UP_VAL: begin
        waddr = idx_up;
        wdata = op_value;
      end
      WR_ZERO_VAL: begin
        waddr = '0;
        wdata = op_value;
      end
      WR_DN_RDATA: begin
        waddr = idx_dn;
        wdata = rdata;
      end
      default: begin
        waddr = '0;
        wdata = rdata;
      end
    endcase
  end

  // single-port-pair store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_sel != WR_NONE) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      unique case (cmd.cnt_op)
        CNT_INC:  fill <= fill + CW'(1);
        CNT_DEC:  fill <= fill_m1;
        CNT_CLR:  fill <= '0;
        default:  fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_op) begin
      op_kind    <= in_kind;
      op_value   <= in_value;
      op_pos     <= in_position;
      res_value  <= '0;
      res_status <= ST_OK;
    end else begin
      if (cmd.capture) begin
        res_value <= rdata;
      end
      if (cmd.set_status) begin
        res_status <= cmd.status;
      end
    end

    unique case (cmd.idx_op)
      IDX_ZERO: idx <= '0;
      IDX_TOP:  idx <= top;
      IDX_STEP: idx <= cmd.idx_down ? idx_dn : idx_up;
      default:  idx <= idx;
    endcase

    if (cmd.out_load) begin
      out_value  <= res_value;
      out_status <= res_status;
      out_count  <= COUNT_W'(fill);
    end
  end

endmodule

// File: sv/sle_ctrl.sv
module sle_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  sle_pkg::dp_stat_t  stat,
  output sle_pkg::dp_cmd_t   cmd
);
  import sle_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_INS_STEP,
    S_INS_BOTTOM,
    S_RMIN_STEP,
    S_CAPTURE,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   load_ok;

  assign in_ready = (state == S_IDLE);
  assign load_ok  = !out_valid || out_ready;

  always_comb begin
    cmd            = '0;
    cmd.rd_sel     = RA_ZERO;
    cmd.wr_sel     = WR_NONE;
    cmd.idx_op     = IDX_HOLD;
    cmd.cnt_op     = CNT_HOLD;
    cmd.status     = ST_OK;
    state_next     = state;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_op = 1'b1;
          state_next   = S_DECODE;
        end
      end

      S_DECODE: begin
        state_next = S_DONE;
        unique case (stat.kind)
          K_INSERT: begin
            if (stat.full) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_FULL;
            end else if (stat.empty) begin
              cmd.wr_sel = WR_ZERO_VAL;
              cmd.cnt_op = CNT_INC;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RA_TOP;
              cmd.idx_op = IDX_TOP;
              state_next = S_INS_STEP;
            end
          end
          K_RMIN: begin
            if (stat.empty) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_EMPTY;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RA_ZERO;
              cmd.idx_op = IDX_ZERO;
              state_next = S_RMIN_STEP;
            end
          end
          K_RMAX: begin
            if (stat.empty) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_EMPTY;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RA_TOP;
              cmd.cnt_op = CNT_DEC;
              state_next = S_CAPTURE;
            end
          end
          K_READ: begin
            if (stat.pos_bad) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_RANGE;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RA_POS;
              state_next = S_CAPTURE;
            end
          end
          K_CLEAR: begin
            cmd.cnt_op = CNT_CLR;
          end
          default: begin
          end
        endcase
      end

      // walk down from the top, moving larger entries up one slot
      S_INS_STEP: begin
        if (stat.greater) begin
          cmd.wr_sel = WR_UP_RDATA;
          if (stat.idx_zero) begin
            state_next = S_INS_BOTTOM;
          end else begin
            cmd.rd_en    = 1'b1;
            cmd.rd_sel   = RA_DN;
            cmd.idx_op   = IDX_STEP;
            cmd.idx_down = 1'b1;
          end
        end else begin
          cmd.wr_sel = WR_UP_VAL;
          cmd.cnt_op = CNT_INC;
          state_next = S_DONE;
        end
      end

      S_INS_BOTTOM: begin
        cmd.wr_sel = WR_ZERO_VAL;
        cmd.cnt_op = CNT_INC;
        state_next = S_DONE;
      end

      // the step at index zero takes the head, later steps shift entries down one slot
      S_RMIN_STEP: begin
        if (stat.idx_zero) begin
          cmd.capture = 1'b1;
        end else begin
          cmd.wr_sel = WR_DN_RDATA;
        end
        if (stat.idx_last) begin
          cmd.cnt_op = CNT_DEC;
          state_next = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RA_UP;
          cmd.idx_op = IDX_STEP;
        end
      end

      S_CAPTURE: begin
        cmd.capture = 1'b1;
        state_next  = S_DONE;
      end

      S_DONE: begin
        if (load_ok) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: sv/sorted_list_engine.sv
// sorted_list_engine: ordered store of up to CAPACITY signed 32-bit values, used as a
// double-ended priority queue. each request beat carries one operation (insert, remove
// smallest, remove largest, read at index, clear) and yields exactly one response beat
// with the value, a status and the count after the operation. one request is in work at
// a time; the entries live in a single memory with one write and one registered read per
// cycle, so entries are moved one at a time. the next request is taken no earlier than
// the cycle after the response register loads. a finished response waits in its register
// while the next request is already accepted; the register loads only once the previous
// response beat has left it, so a stalled response side stalls the block.
module sorted_list_engine #(
  parameter int CAPACITY = sle_pkg::DEFAULT_CAPACITY
) (
  input logic      clk,
  input logic      rst,
  sle_req_if.sink  req,
  sle_rsp_if.source rsp
);
  import sle_pkg::*;

  // command / status link between sequencer and datapath
  dp_cmd_t  cmd;
  dp_stat_t stat;

  sle_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // store, index walker, fill count and response register
  sle_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_kind     (req.kind),
    .in_value    (req.value),
    .in_position (req.position),
    .out_value   (rsp.result_value),
    .out_status  (rsp.status),
    .out_count   (rsp.count)
  );

endmodule

// File: verif/sorted_list_engine_tb.sv
`timescale 1ns / 100ps

module sorted_list_engine_tb;
  import sle_pkg::*;

  localparam int CAPACITY = DEFAULT_CAPACITY;
  // kind codes with no operation behind them
  localparam logic [KIND_W-1:0] K_SPARE_LO = 3'd5;
  localparam logic [KIND_W-1:0] K_SPARE_HI = 3'd7;
  // cycles with no beat on either side before the run is called hung
  localparam int HANG_LIMIT = 2000;
  // beats in this window go through with no random idling on either side
  localparam int CALM_FROM = 420;
  localparam int CALM_TO   = 600;

  typedef struct {
    logic [KIND_W-1:0]         kind;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
    bit                        drain;  // hold this beat until every response is back
  } op_beat_t;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic [1:0]                status;
    logic [COUNT_W-1:0]        count;
  } reply_t;

  logic clk;
  logic rst;

  sle_req_if req_bus ();
  sle_rsp_if rsp_bus ();

  sorted_list_engine #(.CAPACITY(CAPACITY)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  // shadow copy of the ordered store, ascending
  logic signed [VALUE_W-1:0] shadow_list [CAPACITY];
  int                        shadow_len;

  op_beat_t op_queue [$];       // operations not yet presented to the block
  reply_t   reply_queue [$];    // replies owed by the block, oldest first
  int       ops_sent;
  int       replies_seen;
  int       errors;
  int       quiet_cycles;

  // apply one operation to the shadow list and return the reply it earns
  function automatic reply_t apply_op(logic [KIND_W-1:0] kind, logic signed [VALUE_W-1:0] v,
                                      logic [POS_W-1:0] pos);
    reply_t r;
    int     slot;
    r.value  = '0;
    r.status = ST_OK;
    case (kind)
      K_INSERT: begin
        if (shadow_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          // first stored value greater than v; equals stay ahead of the newcomer
          slot = shadow_len;
          for (int i = shadow_len - 1; i >= 0; i--)
            if (shadow_list[i] > v) slot = i;
          for (int i = shadow_len; i > slot; i--)
            shadow_list[i] = shadow_list[i-1];
          shadow_list[slot] = v;
          shadow_len++;
        end
      end
      K_RMIN: begin
        if (shadow_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.value = shadow_list[0];
          for (int i = 1; i < shadow_len; i++)
            shadow_list[i-1] = shadow_list[i];
          shadow_len--;
        end
      end
      K_RMAX: begin
        if (shadow_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          shadow_len--;
          r.value = shadow_list[shadow_len];
        end
      end
      K_READ: begin
        // an empty list always lands here, so unwritten entries are never read
        if (int'(pos) >= shadow_len) r.status = ST_RANGE;
        else r.value = shadow_list[pos];
      end
      K_CLEAR: begin
        shadow_len = 0;
      end
      default: begin
      end
    endcase
    r.count = shadow_len[COUNT_W-1:0];
    return r;
  endfunction

  task automatic queue_op(logic [KIND_W-1:0] kind, logic signed [VALUE_W-1:0] v,
                          logic [POS_W-1:0] pos, bit drain = 1'b0);
    op_beat_t b;
    b.kind     = kind;
    b.value    = v;
    b.position = pos;
    b.drain    = drain;
    op_queue.push_back(b);
  endtask

  // value mix: a narrow band for plenty of ties, the extremes, and full-width noise
  function automatic logic signed [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 40) return $signed($urandom_range(15)) - 8;
    if (r < 45) return 32'sh7fffffff;
    if (r < 50) return 32'sh80000000;
    return $urandom();
  endfunction

  // clock, reset, and known levels on every input from time zero
  initial begin
    clk = 1'b0;
    rst = 1'b1;
    req_bus.valid    = 1'b0;
    req_bus.kind     = '0;
    req_bus.value    = '0;
    req_bus.position = '0;
    rsp_bus.ready    = 1'b0;
    repeat (6) #1 clk = ~clk;
    rst = 1'b0;
    forever #1 clk = ~clk;
  end

  // request driver: one beat per pop, random idle cycles outside the calm window
  always @(posedge clk) begin
    if (rst) begin
      req_bus.valid <= 1'b0;
    end else begin
      // beat accepted at this edge: predict its reply now
      if (req_bus.valid && req_bus.ready) begin
        reply_queue.push_back(apply_op(req_bus.kind, req_bus.value, req_bus.position));
        ops_sent++;
      end
      if (!req_bus.valid || req_bus.ready) begin
        if (op_queue.size() != 0 &&
            (!op_queue[0].drain || reply_queue.size() == 0) &&
            ((ops_sent >= CALM_FROM && ops_sent < CALM_TO) || $urandom_range(99) >= 32)) begin
          req_bus.valid    <= 1'b1;
          req_bus.kind     <= op_queue[0].kind;
          req_bus.value    <= op_queue[0].value;
          req_bus.position <= op_queue[0].position;
          void'(op_queue.pop_front());
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  // response monitor: compare each reply beat with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        replies_seen++;
        if (reply_queue.size() == 0) begin
          errors++;
          $display("%0t: reply with none pending: value %0d status %0d count %0d",
                   $time, rsp_bus.result_value, rsp_bus.status, rsp_bus.count);
        end else begin
          if (rsp_bus.result_value !== reply_queue[0].value) begin
            errors++;
            $display("%0t: result_value expected %0d actual %0d",
                     $time, reply_queue[0].value, rsp_bus.result_value);
          end
          if (rsp_bus.status !== reply_queue[0].status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d",
                     $time, reply_queue[0].status, rsp_bus.status);
          end
          if (rsp_bus.count !== reply_queue[0].count) begin
            errors++;
            $display("%0t: count expected %0d actual %0d",
                     $time, reply_queue[0].count, rsp_bus.count);
          end
          void'(reply_queue.pop_front());
        end
      end
      rsp_bus.ready <= (replies_seen >= CALM_FROM && replies_seen < CALM_TO) ||
                       $urandom_range(99) >= 32;
    end
  end

  // hang detector: nothing moved on either side for too long
  always @(posedge clk) begin
    if (rst || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d replies outstanding",
               $time, quiet_cycles, reply_queue.size());
      $display("sorted_list_engine_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus
  initial begin
    int bias;
    int r;
    ops_sent     = 0;
    replies_seen = 0;
    errors       = 0;
    quiet_cycles = 0;
    shadow_len   = 0;

    // empty list: both removals fail, read of index zero is out of range
    queue_op(K_RMIN, '0, '0);
    queue_op(K_RMAX, '0, '0);
    queue_op(K_READ, '0, '0);
    // fill to capacity with the extremes and ties, then one insert too many
    queue_op(K_INSERT, 32'sh7fffffff, '0);
    queue_op(K_INSERT, 32'sh80000000, '0);
    queue_op(K_INSERT, 32'sh0, '0);
    queue_op(K_INSERT, 32'sh0, '0);
    queue_op(K_INSERT, -32'sh1, '0);
    for (int i = 5; i < CAPACITY; i++)
      queue_op(K_INSERT, $signed(32'(i * 7)) - 40, '0);
    queue_op(K_INSERT, 32'sh55aa55aa, '0);
    // last valid index, first bad index, all-ones index
    queue_op(K_READ, '0, 8'(CAPACITY - 1));
    queue_op(K_READ, '0, 8'(CAPACITY));
    queue_op(K_READ, '0, 8'hff);
    queue_op(K_RMIN, '0, '0);
    queue_op(K_RMAX, '0, '0);
    // unused codes leave the list alone
    queue_op(K_SPARE_LO, 32'sh12345678, 8'h01);
    queue_op(K_SPARE_HI, '0, '0);
    queue_op(K_CLEAR, '0, '0);

    // random part in phases that lean toward filling, draining or a mix;
    // the first beat of some phases waits for the block to go quiet
    for (int n = 0; n < 925; n++) begin
      if (n % 60 == 0) bias = $urandom_range(2);
      r = $urandom_range(99);
      if (r < 3) begin
        queue_op(KIND_W'($urandom_range(K_SPARE_LO, K_SPARE_HI)), $urandom(),
                 POS_W'($urandom_range(255)), n % 240 == 0);
      end else if (r < 5) begin
        queue_op(K_CLEAR, $urandom(), POS_W'($urandom_range(255)), n % 240 == 0);
      end else begin
        r = $urandom_range(99);
        case (bias)
          0: r = (r < 70) ? 0 : r;   // mostly inserts, reaches a full store
          1: r = (r < 25) ? 0 : r;   // mostly removals and reads
          default: r = (r < 45) ? 0 : r;
        endcase
        if (r == 0)
          queue_op(K_INSERT, pick_value(), POS_W'($urandom_range(255)), n % 240 == 0);
        else if (r < 55)
          queue_op(K_READ, $urandom(),
                   POS_W'(($urandom_range(99) < 80) ? $urandom_range(CAPACITY + 1)
                                                    : $urandom_range(255)),
                   n % 240 == 0);
        else if (r < 78)
          queue_op(K_RMIN, $urandom(), POS_W'($urandom_range(255)), n % 240 == 0);
        else
          queue_op(K_RMAX, $urandom(), POS_W'($urandom_range(255)), n % 240 == 0);
      end
    end

    // drain everything, then give the block time for any stray reply
    do @(posedge clk);
    while (op_queue.size() != 0 || req_bus.valid || reply_queue.size() != 0);
    repeat (40) @(posedge clk);
    if (errors == 0 && reply_queue.size() == 0) begin
      $display("sorted_list_engine_tb OK");
    end else begin
      $display("sorted_list_engine_tb NOT OK");
    end
    $finish;
  end

endmodule
